>>> rtl/ookspe_pkg.sv
// Package for the OOK slicer pulse extractor: payload structs, codes,
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ookspe_pkg;

    localparam int VOTE_WINDOW      = 11;
    localparam int RSSI_EXTRA_DELAY = 2;
    localparam int DELAY_LEN        = VOTE_WINDOW + RSSI_EXTRA_DELAY + 1;
    localparam int DELAY_BACK       = (VOTE_WINDOW / 2) + RSSI_EXTRA_DELAY;
    localparam int DIDX_W           = $clog2(DELAY_LEN);
    localparam int VCNT_W           = $clog2(VOTE_WINDOW + 1);

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_EDGE   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [2:0] CFG_FLUSH_LIMIT   = 3'd1;
    localparam logic [2:0] CFG_INIT_FIXED    = 3'd2;
    localparam logic [2:0] CFG_STAT_SPACING  = 3'd3;
    localparam logic [2:0] CFG_UPDATE_PERIOD = 3'd4;

    localparam logic [7:0]  PEAK_RESET    = 8'd100;
    localparam logic [7:0]  PEAK_MARGIN   = 8'd12;
    localparam logic [7:0]  PEAK_CAP      = 8'd188;
    localparam logic [7:0]  RSSI_CAP      = 8'd200;
    localparam logic [31:0] VAR_LIMIT     = 32'd36;
    localparam logic [4:0]  DELTA_MIN     = 5'd6;

    typedef struct packed {
        logic       data_bit;
        logic [7:0] rssi_raw;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pulse_duration;
        logic        pulse_level;
        logic [7:0]  pulse_rssi;
        logic        filtered_data;
        logic [7:0]  slice_threshold;
        logic [7:0]  fixed_threshold;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        SEL_EDGE   = 2'd0,
        SEL_END1   = 2'd1,
        SEL_END2   = 2'd2,
        SEL_STATUS = 2'd3
    } t_sel;

    typedef enum logic [1:0] {
        DIV_Q   = 2'd0,
        DIV_VAR = 2'd1,
        DIV_AVG = 2'd2
    } t_dsel;

    typedef struct packed {
        logic  take;
        logic  calc;
        logic  clear_stats;
        logic  div_start;
        t_dsel div_sel;
        logic  cap_q;
        logic  mul;
        logic  cap_var;
        logic  cap_avg;
        logic  apply;
        logic  thr;
        logic  load_out;
        t_sel  out_sel;
    } t_cmd;

    typedef struct packed {
        logic       adapt_due;
        logic       enough;
        logic       div_done;
        logic       div_busy;
        logic [1:0] kind;
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/ookspe_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per clock.
// Depends on nothing; used by the datapath for the floor adaptation.
`timescale 1ns / 1ps
`default_nettype none
module ookspe_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_dvs;
    logic [32:0] w_shift;
    logic [32:0] w_trial;

    assign w_shift = {r_rem, r_dvd[31]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // keep the difference when it does not go negative
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_dvd <= {r_dvd[30:0], 1'b1};
            end else begin
                r_rem <= w_shift[31:0];
                r_dvd <= {r_dvd[30:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_dvd;
endmodule
`default_nettype wire

>>> rtl/ookspe_ctrl.sv
// Tick sequencer: steps the datapath through evaluation, adaptation and
// result transfers. Depends on ookspe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ookspe_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ookspe_pkg::t_status i_st,
    output ookspe_pkg::t_cmd        o_cmd
);
    import ookspe_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CALC   = 11'b00000000010,
        S_CHECK  = 11'b00000000100,
        S_DIV1   = 11'b00000001000,
        S_MUL    = 11'b00000010000,
        S_START2 = 11'b00000100000,
        S_DIV2   = 11'b00001000000,
        S_DIV3   = 11'b00010000000,
        S_APPLY  = 11'b00100000000,
        S_THR    = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    t_sel   r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (!i_st.adapt_due) begin
                    n_state = S_THR;
                end else if (!i_st.enough) begin
                    o_cmd.clear_stats = 1'b1;
                    n_state           = S_THR;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_Q;
                    n_state         = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_st.div_done) begin
                    o_cmd.cap_q = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_START2;
            end
            S_START2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_VAR;
                n_state         = S_DIV2;
            end
            S_DIV2: begin
                if (i_st.div_done) begin
                    o_cmd.cap_var   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_AVG;
                    n_state         = S_DIV3;
                end
            end
            S_DIV3: begin
                if (i_st.div_done) begin
                    o_cmd.cap_avg = 1'b1;
                    n_state       = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_THR;
            end
            S_THR: begin
                o_cmd.thr = 1'b1;
                n_state   = S_EMIT;
                if (i_st.kind == KIND_EDGE) begin
                    n_sel = SEL_EDGE;
                end else if (i_st.kind == KIND_END) begin
                    n_sel = SEL_END1;
                end else begin
                    n_sel = SEL_STATUS;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = r_sel;
                    case (r_sel)
                        SEL_END1: n_sel   = SEL_END2;
                        SEL_STATUS: n_state = S_IDLE;
                        default: n_sel   = SEL_STATUS;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_STATUS;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_st.out_free)
        else $error("result loaded while output register is occupied");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_start && r_state != S_DIV2) |-> !i_st.div_busy)
        else $error("divider started while busy");

    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && r_sel == SEL_STATUS) |=> r_state == S_IDLE)
        else $error("tick did not close after its status result");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> r_state == S_CALC)
        else $error("accepted tick did not start evaluation");
endmodule
`default_nettype wire

>>> rtl/ookspe_dpath.sv
// Datapath: vote filter, RSSI delay line, pulse timing, statistics,
// thresholds and output register. Depends on ookspe_pkg and ookspe_div.
`timescale 1ns / 1ps
`default_nettype none
module ookspe_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ookspe_pkg::t_in    i_in_data,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire ookspe_pkg::t_cmd   i_cmd,
    output ookspe_pkg::t_status     o_st,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ookspe_pkg::t_out        o_out_data
);
    import ookspe_pkg::*;

    // configuration
    logic [7:0]  r_period;
    logic [15:0] r_flush;
    logic [15:0] r_spacing;
    logic [31:0] r_upd_period;

    // tick state
    logic [VOTE_WINDOW-1:0] r_hist;
    logic [7:0]             r_dline [DELAY_LEN];
    logic [DIDX_W-1:0]      r_didx;
    logic                   r_held;
    logic [31:0]            r_tick;
    logic [31:0]            r_edge;
    logic [15:0]            r_quiet;
    logic [7:0]             r_steady;
    logic [7:0]             r_peak;
    logic [7:0]             r_floor;
    logic [2:0]             r_phase;
    logic [31:0]            r_sum;
    logic [31:0]            r_sq;
    logic [31:0]            r_nsamp;
    logic [31:0]            r_stick;
    logic [31:0]            r_utick;
    logic                   r_due;
    logic [1:0]             r_kind;
    logic                   r_ovalid;

    // per-tick payload
    logic        r_bit;
    logic [7:0]  r_rssi;
    logic        r_filt;
    logic [15:0] r_dur;
    logic        r_lvl;
    logic [7:0]  r_srs;
    logic [31:0] r_q;
    logic [31:0] r_prod;
    logic [31:0] r_var;
    logic [31:0] r_avg;
    t_out        r_out;

    logic [VOTE_WINDOW-1:0] w_hist;
    logic [VCNT_W-1:0]      w_cnt;
    logic                   w_filt;
    logic [DIDX_W-1:0]      w_rd;
    logic [DIDX_W-1:0]      w_didx_nx;
    logic [31:0]            w_span;
    logic [39:0]            w_dur_full;
    logic [15:0]            w_dur;
    logic                   w_edge;
    logic                   w_end;
    logic                   w_stat;
    logic [15:0]            w_sq;
    logic [55:0]            w_prod_full;
    logic [3:0]             w_sd;
    logic [4:0]             w_delta;
    logic [32:0]            w_fsum;
    logic [2:0]             w_phase;
    logic [7:0]             w_peak_dec;
    logic [8:0]             w_peak_top;
    logic [7:0]             w_peak;
    logic [31:0]            w_dvd;
    logic [31:0]            w_dvs;
    logic                   w_div_busy;
    logic                   w_div_done;
    logic [31:0]            w_quot;
    logic                   w_out_free;

    function automatic logic [3:0] f_isqrt_ceil(input logic [31:0] v);
        logic [3:0] s;
        s = 4'd10;
        for (int k = 9; k >= 1; k--) begin
            if (32'(k * k) >= v) begin
                s = 4'(k);
            end
        end
        return s;
    endfunction

    assign w_hist    = {r_hist[VOTE_WINDOW-2:0], r_bit};
    assign w_cnt     = VCNT_W'($countones(w_hist));
    assign w_filt    = (w_cnt > VCNT_W'(VOTE_WINDOW / 2));
    assign w_rd      = (r_didx >= DIDX_W'(DELAY_BACK)) ? r_didx - DIDX_W'(DELAY_BACK)
                                                      : r_didx + DIDX_W'(DELAY_LEN - DELAY_BACK);
    assign w_didx_nx = (r_didx == DIDX_W'(DELAY_LEN - 1)) ? '0 : r_didx + 1'b1;

    assign w_span     = r_tick - r_edge;
    assign w_dur_full = 40'(w_span) * 40'(r_period);
    assign w_dur      = (w_dur_full > 40'd65535) ? 16'hFFFF : w_dur_full[15:0];
    assign w_edge     = (w_filt != r_held);
    assign w_end      = !w_edge && (r_quiet == r_flush);
    assign w_stat     = ((r_tick - r_stick) > {16'd0, r_spacing});
    assign w_sq       = 16'(r_rssi) * 16'(r_rssi);

    assign w_prod_full = 56'(r_sum[31:8]) * 56'(r_q);

    assign w_sd    = f_isqrt_ceil(r_var);
    assign w_delta = ((5'(w_sd) * 5'd3) < DELTA_MIN) ? DELTA_MIN : 5'(w_sd) * 5'd3;
    assign w_fsum  = {1'b0, r_avg} + 33'(w_delta);

    // decay every eighth tick, then jump toward the new RSSI
    assign w_phase    = r_phase + 3'd1;
    assign w_peak_dec = ((w_phase == 3'd0) && (r_peak > r_floor)) ? r_peak - 8'd1 : r_peak;
    assign w_peak_top = {1'b0, w_peak_dec} + {1'b0, PEAK_MARGIN};
    always_comb begin
        w_peak = w_peak_dec;
        if ({1'b0, r_rssi} > w_peak_top) begin
            w_peak = (r_rssi > RSSI_CAP) ? PEAK_CAP : r_rssi - PEAK_MARGIN;
            if (w_peak < r_floor) begin
                w_peak = r_floor;
            end
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_Q: begin
                w_dvd = {r_sum[23:0], 8'd0};
                w_dvs = r_nsamp;
            end
            DIV_VAR: begin
                w_dvd = r_sq - r_prod;
                w_dvs = r_nsamp - 32'd1;
            end
            default: begin
                w_dvd = r_sum;
                w_dvs = r_nsamp;
            end
        endcase
    end

    ookspe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= 8'd25;
            r_flush      <= 16'd200;
            r_spacing    <= 16'd40;
            r_upd_period <= 32'd400000;
            r_hist       <= '0;
            for (int k = 0; k < DELAY_LEN; k++) begin
                r_dline[k] <= '0;
            end
            r_didx   <= '0;
            r_held   <= 1'b0;
            r_tick   <= '0;
            r_edge   <= '0;
            r_quiet  <= '0;
            r_steady <= '0;
            r_peak   <= PEAK_RESET;
            r_floor  <= 8'd60;
            r_phase  <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_nsamp  <= '0;
            r_stick  <= '0;
            r_utick  <= '0;
            r_due    <= 1'b0;
            r_kind   <= KIND_STATUS;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_PERIOD: r_period     <= i_cfg_data[7:0];
                    CFG_FLUSH_LIMIT:   r_flush      <= i_cfg_data[15:0];
                    CFG_INIT_FIXED:    r_floor      <= i_cfg_data[7:0];
                    CFG_STAT_SPACING:  r_spacing    <= i_cfg_data[15:0];
                    CFG_UPDATE_PERIOD: r_upd_period <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.calc) begin
                r_hist          <= w_hist;
                r_dline[r_didx] <= r_rssi;
                r_didx          <= w_didx_nx;
                r_steady        <= r_dline[w_rd];
                if (w_edge) begin
                    r_edge  <= r_tick;
                    r_held  <= w_filt;
                    r_quiet <= 16'd1;
                    r_kind  <= KIND_EDGE;
                end else begin
                    r_quiet <= r_quiet + 16'd1;
                    r_kind  <= w_end ? KIND_END : KIND_STATUS;
                end
                if (w_stat) begin
                    r_sum   <= r_sum + 32'(r_rssi);
                    r_sq    <= r_sq + 32'(w_sq);
                    r_nsamp <= r_nsamp + 32'd1;
                    r_stick <= r_tick;
                end
                r_due <= ((r_tick - r_utick) >= r_upd_period);
            end
            if (i_cmd.clear_stats || i_cmd.apply) begin
                r_sum   <= '0;
                r_sq    <= '0;
                r_nsamp <= '0;
                r_utick <= r_tick;
            end
            if (i_cmd.apply && (r_var < VAR_LIMIT)) begin
                r_floor <= (w_fsum > 33'd255) ? 8'd255 : w_fsum[7:0];
            end
            if (i_cmd.thr) begin
                r_phase <= w_phase;
                r_peak  <= w_peak;
                r_tick  <= r_tick + 32'd1;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_bit  <= i_in_data.data_bit;
            r_rssi <= ~i_in_data.rssi_raw;
        end
        if (i_cmd.calc) begin
            r_filt <= w_filt;
            r_dur  <= w_dur;
            r_lvl  <= r_held;
            r_srs  <= r_steady;
        end
        if (i_cmd.cap_q) begin
            r_q <= w_quot;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod_full[31:0];
        end
        if (i_cmd.cap_var) begin
            r_var <= w_quot;
        end
        if (i_cmd.cap_avg) begin
            r_avg <= w_quot;
        end
        if (i_cmd.load_out) begin
            r_out.filtered_data   <= r_filt;
            r_out.slice_threshold <= r_peak;
            r_out.fixed_threshold <= r_floor;
            case (i_cmd.out_sel)
                SEL_EDGE: begin
                    r_out.kind           <= KIND_EDGE;
                    r_out.pulse_duration <= r_dur;
                    r_out.pulse_level    <= r_lvl;
                    r_out.pulse_rssi     <= r_srs;
                    r_out.last           <= 1'b0;
                end
                SEL_END1: begin
                    r_out.kind           <= KIND_END;
                    r_out.pulse_duration <= r_dur;
                    r_out.pulse_level    <= r_lvl;
                    r_out.pulse_rssi     <= '0;
                    r_out.last           <= 1'b0;
                end
                SEL_END2: begin
                    r_out.kind           <= KIND_END;
                    r_out.pulse_duration <= 16'd1;
                    r_out.pulse_level    <= ~r_lvl;
                    r_out.pulse_rssi     <= '0;
                    r_out.last           <= 1'b0;
                end
                default: begin
                    r_out.kind           <= KIND_STATUS;
                    r_out.pulse_duration <= '0;
                    r_out.pulse_level    <= 1'b0;
                    r_out.pulse_rssi     <= '0;
                    r_out.last           <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_st.adapt_due = r_due;
        o_st.enough    = (r_nsamp >= 32'd2);
        o_st.div_done  = w_div_done;
        o_st.div_busy  = w_div_busy;
        o_st.kind      = r_kind;
        o_st.out_free  = w_out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

>>> rtl/ook_slicer_pulse_extractor_core.sv
// OOK slicer pulse extractor top level: controller plus datapath.
// Depends on ookspe_pkg, ookspe_ctrl, ookspe_dpath.
`timescale 1ns / 1ps
`default_nettype none
// One sample tick is taken per transfer on the input channel and yields one
// to three results, the last always a status result with last set. No new
// tick is taken until that status result has been loaded into the output
// register, which waits while the output side stalls. A tick on which the
// fixed threshold adapts also makes three passes of the shared bit-serial
// divider. Configuration writes go straight to the registers; writing
// register 2 also reloads the fixed threshold.
module ook_slicer_pulse_extractor_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire ookspe_pkg::t_in  i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output ookspe_pkg::t_out      o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic [31:0]      i_cfg_data
);
    import ookspe_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;

    ookspe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    ookspe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire
